[rtl/core/csf_pkg.sv]
// ----------------------------------------------------------------------------
// csf_pkg
// Shared sizes, codes and payload types of the counting semaphore block.
// ----------------------------------------------------------------------------
`default_nettype none

package csf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int COUNT_BITS  = 16;
  localparam int CFG_BITS    = 16;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic MODE_DOWN = 1'b0;
  localparam logic MODE_UP   = 1'b1;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_BLOCKED   = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_WOKE      = 3'd3,
    ST_QFULL     = 3'd4,
    ST_SATURATED = 3'd5
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_t;

  typedef struct packed {
    logic               mode;
    logic [ID_BITS-1:0] thread_id;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic                  woken_valid;
    logic [ID_BITS-1:0]    woken_id;
    logic [COUNT_BITS-1:0] count_now;
    logic [OCC_BITS-1:0]   waiters_now;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/core/csf_ram.sv]
// ----------------------------------------------------------------------------
// csf_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module csf_ram #(
  parameter int DEPTH     = 16,
  parameter int WIDTH     = 8,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/counting_semaphore_fifo_waiters.sv]
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters
// Counting semaphore with a FIFO queue of blocked requester ids.
// ----------------------------------------------------------------------------
//
//  channel | signals                       | moves
//  --------+-------------------------------+---------------------------------
//  in      | in_valid  in_ready  in_data   | one down/up request
//  out     | out_valid out_ready out_data  | one result per request
//  cfg     | cfg_valid cfg_ready cfg_data  | initial_count write (re-create)
//
//  A request is accepted only in idle; the accept edge launches the head read
//  from the waiter RAM (registered read), and execute then decides, updates
//  count and pointers and writes a blocked id once the output slot is free.
//  Synchronous reset clears count, pointers and occupancy, not the RAM.
//  A stalled result holds in the output register; the next request is still
//  accepted and waits in execute for the slot.
//
`default_nettype none

module counting_semaphore_fifo_waiters
  import csf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire in_item_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output out_item_t                out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CFG_BITS-1:0] cfg_data
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [PTR_BITS-1:0]   PTR_LAST  = PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [OCC_BITS-1:0]   OCC_FULL  = OCC_BITS'(QUEUE_DEPTH);

  // control state
  fsm_t                  state_r, state_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [PTR_BITS-1:0]   head_r, head_nxt;
  logic [PTR_BITS-1:0]   tail_r, tail_nxt;
  logic [OCC_BITS-1:0]   occ_r, occ_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // payload
  in_item_t              item_r;
  out_item_t             res_r, res_nxt;

  logic                  in_fire, cfg_fire, slot_free, commit;
  logic                  ram_we;
  logic [ID_BITS-1:0]    head_id;

  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign slot_free = !out_valid_r || out_ready;

  // Waiter queue. Read port tracks the head every cycle, so the id is
  // ready in the execute cycle. Writes happen only in execute, so the
  // accept-edge read never races a write.
  csf_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ID_BITS)
  ) u_waiters (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (item_r.thread_id),
    .raddr (head_r),
    .rdata (head_id)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_fire) begin
          state_nxt = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (slot_free) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // FSM outputs; config has priority over a request in idle
  always_comb begin
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    commit    = 1'b0;
    case (state_r)
      FSM_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
      end
      FSM_EXEC: begin
        commit = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // request datapath
  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    occ_nxt   = occ_r;
    ram_we    = 1'b0;
    res_nxt   = res_r;

    if (commit) begin
      res_nxt.woken_valid = 1'b0;
      res_nxt.woken_id    = '0;
      if (item_r.mode == MODE_DOWN) begin
        if (count_r != '0) begin
          count_nxt      = count_r - 1'b1;
          res_nxt.status = ST_GRANTED;
        end else if (occ_r != OCC_FULL) begin
          ram_we         = 1'b1;
          tail_nxt       = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
          occ_nxt        = occ_r + 1'b1;
          res_nxt.status = ST_BLOCKED;
        end else begin
          res_nxt.status = ST_QFULL;
        end
      end else begin
        if (occ_r != '0) begin
          // unit goes straight to the oldest waiter, count unchanged
          res_nxt.woken_valid = 1'b1;
          res_nxt.woken_id    = head_id;
          head_nxt            = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
          occ_nxt             = occ_r - 1'b1;
          res_nxt.status      = ST_WOKE;
        end else if (count_r == COUNT_MAX) begin
          res_nxt.status = ST_SATURATED;
        end else begin
          count_nxt      = count_r + 1'b1;
          res_nxt.status = ST_RELEASED;
        end
      end
      res_nxt.count_now   = count_nxt;
      res_nxt.waiters_now = occ_nxt;
    end

    // re-create: reload count, empty the queue
    if (cfg_fire) begin
      count_nxt = COUNT_BITS'(cfg_data);
      head_nxt  = '0;
      tail_nxt  = '0;
      occ_nxt   = '0;
    end
  end

  assign out_valid_nxt = commit || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
    end
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_FULL)
    else $error("waiter occupancy above queue depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == '0 |-> head_r == tail_r)
    else $error("empty queue with head and tail apart");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == FSM_EXEC && !in_ready && !cfg_ready)
    else $error("accepted transaction not held in execute");

  a_woken_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.woken_valid == (res_r.status == ST_WOKE)))
    else $error("woken flag disagrees with status");
`endif

endmodule

`default_nettype wire

[tb/csf_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csf_result_checker
// Watches the request, result and configuration channels of the counting
// semaphore, keeps its own copy of count and wait queue, and compares every
// result transaction field by field against the predicted one.
// ----------------------------------------------------------------------------

module csf_result_checker
  import csf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_item_t           out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CFG_BITS-1:0] cfg_data,
  output int                  n_pending,
  output int                  fail_count,
  output int                  n_checked,
  output logic [5:0]          status_seen
);

  // Shadow semaphore.
  logic [COUNT_BITS-1:0] init_count;
  logic [COUNT_BITS-1:0] sem_count;
  logic [ID_BITS-1:0]    waiter_ids [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wq_head;
  logic [PTR_BITS-1:0]   wq_tail;
  logic [OCC_BITS-1:0]   wq_size;

  out_item_t pending_results [$];
  int        fails   = 0;
  int        checked = 0;
  logic [5:0] seen   = '0;

  // Re-create: load the count, empty the queue.
  function automatic void reload_semaphore();
    sem_count = init_count;
    wq_head   = '0;
    wq_tail   = '0;
    wq_size   = '0;
  endfunction

  // Apply one request to the shadow state, return the result it must give.
  function automatic out_item_t predict_request(in_item_t req);
    out_item_t r;
    r = '0;
    if (req.mode == MODE_DOWN) begin
      if (sem_count != '0) begin
        sem_count = sem_count - 1'b1;
        r.status  = ST_GRANTED;
      end else if (int'(wq_size) < QUEUE_DEPTH) begin
        waiter_ids[wq_tail] = req.thread_id;
        wq_tail  = wq_tail + 1'b1;
        wq_size  = wq_size + 1'b1;
        r.status = ST_BLOCKED;
      end else begin
        r.status = ST_QFULL;
      end
    end else begin
      if (wq_size != '0) begin
        r.woken_valid = 1'b1;
        r.woken_id    = waiter_ids[wq_head];
        wq_head  = wq_head + 1'b1;
        wq_size  = wq_size - 1'b1;
        r.status = ST_WOKE;
      end else if (sem_count == '1) begin
        r.status = ST_SATURATED;
      end else begin
        sem_count = sem_count + 1'b1;
        r.status  = ST_RELEASED;
      end
    end
    r.count_now   = sem_count;
    r.waiters_now = wq_size;
    return r;
  endfunction

  function automatic int field_diff(string fname, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", fname, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    int        bad;
    if (!rst_n) begin
      init_count = '0;
      reload_semaphore();
      pending_results.delete();
    end else begin
      // Result side first: a result never belongs to a request taken at the same edge.
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no request outstanding (status %0d)",
                 int'(out_data.status));
          fails++;
        end else begin
          want = pending_results.pop_front();
          bad  = 0;
          bad += field_diff("status",      int'(want.status), int'(out_data.status));
          bad += field_diff("woken_valid", want.woken_valid,  out_data.woken_valid);
          bad += field_diff("woken_id",    want.woken_id,     out_data.woken_id);
          bad += field_diff("count_now",   want.count_now,    out_data.count_now);
          bad += field_diff("waiters_now", want.waiters_now,  out_data.waiters_now);
          if (bad != 0) fails++;
          checked++;
          seen[int'(want.status)] = 1'b1;
        end
      end
      if (cfg_valid && cfg_ready) begin
        init_count = cfg_data;
        reload_semaphore();
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(predict_request(in_data));
      end
    end
    n_pending   <= pending_results.size();
    fail_count  <= fails;
    n_checked   <= checked;
    status_seen <= seen;
  end

endmodule

[tb/tb_counting_semaphore_fifo_waiters.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_counting_semaphore_fifo_waiters
// Stimulus and verdict for the counting semaphore with FIFO wait queue.
// Drives down/up requests in random bursts under a stalling receiver, walks
// initial_count through several settings including both extremes, and lets
// the checker compare every result against its own shadow semaphore.
// ----------------------------------------------------------------------------

module tb_counting_semaphore_fifo_waiters;
  import csf_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;  // bound well above the slowest legal run
  localparam int LONG_HOLD    = 400;     // receiver back-pressure stretch
  localparam int N_PHASES     = 6;
  localparam int PHASE_ITEMS  = 292;     // ~1750 random requests in total
  localparam int TAIL_CYCLES  = 8;       // run-out after the last result

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_BITS-1:0] cfg_data  = '0;

  int         n_pending;
  int         fail_count;
  int         n_checked;
  logic [5:0] status_seen;

  // Set once by the stimulus; the receiver then stalls for the LONG_HOLD stretch.
  logic hold_go = 1'b0;

  int burst_left   = 0;  // requests left in the current sender burst
  int n_sent       = 0;
  int n_settings   = 0;

  counting_semaphore_fifo_waiters DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  csf_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .n_pending   (n_pending),
    .fail_count  (fail_count),
    .n_checked   (n_checked),
    .status_seen (status_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing result ends here.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Receiver: stretches of steady, sparse or full readiness, plus one long
  // hold-off so the block backs up and drops in_ready while requests keep coming.
  initial begin : receiver
    int stretch;
    int ready_pct;
    bit hold_done;
    stretch   = 0;
    ready_pct = 100;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (stretch == 0) begin
        stretch = $urandom_range(10, 80);
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 70;
          2: ready_pct = 40;
          default: ready_pct = 10;
        endcase
      end
      stretch--;
      out_ready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  // Offer one request transaction and return at the edge that accepts it.
  // in_valid stays high afterwards, so back-to-back requests never drop it;
  // gaps only fall between bursts.
  task automatic offer_request(input logic m, input logic [ID_BITS-1:0] id);
    in_item_t req;
    int       gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req.mode      = m;
    req.thread_id = id;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  // Stop offering and wait until the checker has seen every result.
  // The wait before the first check lets the checker count a request taken at the last edge.
  task automatic drain_results();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  // initial_count write; only issued with the block idle.
  task automatic load_initial_count(input logic [CFG_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin : stimulus
    logic [CFG_BITS-1:0] phase_count [N_PHASES];
    int                  down_pct    [N_PHASES];
    logic                m;

    // Settings per random phase: empty, saturated, near-empty, near-max,
    // arbitrary, small. The down bias steers toward a full queue or a full count.
    phase_count = '{16'd0, 16'hFFFF, 16'd1, 16'hFFFC, 16'd0, 16'd7};
    phase_count[4] = CFG_BITS'($urandom_range(0, 65535));
    down_pct    = '{65, 25, 50, 45, 55, 60};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: reset value of initial_count is 0 ----
    offer_request(MODE_UP,   8'h12);   // released, count 1
    offer_request(MODE_DOWN, 8'h34);   // granted, count 0
    offer_request(MODE_DOWN, 8'h00);   // blocked, lowest id
    offer_request(MODE_DOWN, 8'hFF);   // blocked, highest id
    offer_request(MODE_UP,   8'h00);   // wakes id 0x00
    offer_request(MODE_UP,   8'hFF);   // wakes id 0xFF
    // fill the wait queue, then one more down is refused
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      offer_request(MODE_DOWN, (i % 2 == 0) ? 8'hAA : 8'h55);
    end
    offer_request(MODE_DOWN, 8'h77);   // queue full
    offer_request(MODE_UP,   8'h01);   // wakes the oldest
    drain_results();

    // count at its maximum: saturation on up
    load_initial_count(16'hFFFF);
    offer_request(MODE_UP,   8'h01);   // saturated
    offer_request(MODE_DOWN, 8'h02);   // granted, count max-1
    offer_request(MODE_UP,   8'h03);   // released back to max
    drain_results();

    // ---- random phases ----
    for (int p = 0; p < N_PHASES; p++) begin
      load_initial_count(phase_count[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == 100) hold_go <= 1'b1;
        m = ($urandom_range(1, 100) <= down_pct[p]) ? MODE_DOWN : MODE_UP;
        offer_request(m, ID_BITS'($urandom_range(0, 255)));
      end
      // sender pauses here until every result is back
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run: %0d requests sent, %0d results checked, %0d initial_count settings",
             n_sent, n_checked, n_settings);
    $display("run: status codes seen (bit per code, 5..0) = %b", status_seen);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/csf_pkg.sv
rtl/core/csf_ram.sv
rtl/core/counting_semaphore_fifo_waiters.sv
tb/csf_result_checker.sv
tb/tb_counting_semaphore_fifo_waiters.sv
